[rtl/ll1p_pkg.sv]
// Shared types, constants and codes of the LL(1) token parser.
package ll1p_pkg;

   localparam int NumProductions = 64;
   localparam int MaxProdLen     = 16;
   localparam int TableSlots     = 64;
   localparam int StackDepth     = 16;
   localparam int MaxExpansions  = 16;
   localparam int SymbolBits     = 12;

   localparam int NONTERMINAL_BASE = 2000;
   localparam int BRACKET_LO       = 1006;
   localparam int BRACKET_HI       = 1009;

   localparam logic [1:0] REQ_WRITE_SYMBOL = 2'd0;
   localparam logic [1:0] REQ_WRITE_SLOT   = 2'd1;
   localparam logic [1:0] REQ_TOKEN        = 2'd2;
   localparam logic [1:0] REQ_RESTART      = 2'd3;

   localparam logic [2:0] ST_MATCHED  = 3'd0;
   localparam logic [2:0] ST_COMPLETE = 3'd1;
   localparam logic [2:0] ST_MISMATCH = 3'd2;
   localparam logic [2:0] ST_OVERFLOW = 3'd3;
   localparam logic [2:0] ST_DONE     = 3'd4;

   localparam logic CSR_PRODUCTION_COUNT = 1'b0;
   localparam logic CSR_EMPTY_SYMBOL     = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FETCH,
      S_DECIDE,
      S_SEARCH,
      S_EXPAND,
      S_EMIT
   } state_type;

   // Datapath commands from the controller.
   typedef struct packed {
      logic load_item;
      logic write_store;
      logic restart;
      logic fetch;
      logic pop;
      logic advance;
      logic search_start;
      logic search_step;
      logic push;
      logic emit_expand;
      logic emit_status;
      logic set_repaired;
      logic [2:0] status;
      logic [1:0] finish;
   } cmd_type;

   // Status of the datapath to the controller.
   typedef struct packed {
      logic [1:0] req_type;
      logic       stopped;
      logic       top_over;
      logic       have_sym;
      logic       level_one;
      logic       sym_eq;
      logic       sym_nt;
      logic       sym_bracket;
      logic       search_done;
      logic       search_hit;
      logic       exp_limit;
      logic       stack_full;
      logic       out_busy;
   } stat_type;

endpackage

[rtl/ll1p_datapath.sv]
// Parser datapath: stores, stack, table search and result register.
module ll1p_datapath #(
   parameter int NUM_PRODUCTIONS = ll1p_pkg::NumProductions,
   parameter int MAX_PROD_LEN    = ll1p_pkg::MaxProdLen,
   parameter int TABLE_SLOTS     = ll1p_pkg::TableSlots,
   parameter int STACK_DEPTH     = ll1p_pkg::StackDepth,
   parameter int MAX_EXPANSIONS  = ll1p_pkg::MaxExpansions
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ll1p_pkg::cmd_type      cmd,
   output ll1p_pkg::stat_type     stat,
   input  logic [1:0]             req_type,
   input  logic [5:0]             req_production,
   input  logic [3:0]             req_position,
   input  logic [11:0]            req_symbol,
   input  logic [5:0]             req_table_slot,
   input  logic [11:0]            req_key_nonterminal,
   input  logic [11:0]            req_key_token,
   input  logic                   req_entry_valid,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [11:0]            csr_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_kind,
   output logic [5:0]             rsp_applied_production,
   output logic [2:0]             rsp_status,
   output logic                   rsp_repaired,
   output logic                   rsp_last
);
   localparam int PB = $clog2(NUM_PRODUCTIONS);
   localparam int LB = $clog2(MAX_PROD_LEN);
   localparam int TB = $clog2(TABLE_SLOTS);
   localparam int SB = $clog2(STACK_DEPTH);
   localparam int LVB = $clog2(STACK_DEPTH + 1);
   localparam int EB = $clog2(MAX_EXPANSIONS + 1);

   // Held item.
   logic [1:0]  it_type_ff;
   logic [5:0]  it_prod_ff;
   logic [3:0]  it_pos_ff;
   logic [11:0] it_sym_ff;
   logic [5:0]  it_slot_ff;
   logic [23:0] it_key_ff;
   logic        it_kv_ff;

   logic [6:0]  prod_count_ff;
   logic [11:0] empty_sym_ff;

   logic [11:0] sym_mem [NUM_PRODUCTIONS*MAX_PROD_LEN];
   logic [4:0]  len_mem [NUM_PRODUCTIONS];
   logic [NUM_PRODUCTIONS-1:0] len_set_ff;
   logic [23:0] key_mem [TABLE_SLOTS];
   logic [5:0]  tgt_mem [TABLE_SLOTS];
   logic [TABLE_SLOTS-1:0] tvalid_ff;

   logic [5:0]  stk_prod_ff [STACK_DEPTH];
   logic [4:0]  stk_cur_ff [STACK_DEPTH];
   logic [LVB-1:0] level_ff;
   logic [1:0]  finished_ff;
   logic [EB-1:0] exp_ff;
   logic        rep_ff;

   logic [11:0] sym_rd_ff;
   logic [4:0]  len_rd_ff;
   logic [4:0]  len_old_ff;
   logic        have_ff;
   logic [TB:0] scan_ff;
   logic        hit_ff;
   logic [5:0]  hit_tgt_ff;
   logic [23:0] key_rd_ff;
   logic [5:0]  tgt_rd_ff;
   logic        kv_rd_ff;
   logic        rd_pend_ff;

   logic        out_valid_ff;
   logic        out_kind_ff;
   logic [5:0]  out_prod_ff;
   logic [2:0]  out_status_ff;
   logic        out_rep_ff;

   logic [SB-1:0] top;
   logic [5:0]  top_prod;
   logic [4:0]  top_cur;
   logic        fetch_ok;
   logic [SB-1:0] below;
   logic        len_wr;
   logic [4:0]  new_len;

   always_comb begin
      top = SB'(level_ff - LVB'(1));
      below = SB'(level_ff - LVB'(2));
      top_prod = stk_prod_ff[top];
      top_cur = stk_cur_ff[top];
      fetch_ok = (7'(top_prod) < prod_count_ff) && (32'(top_prod) < NUM_PRODUCTIONS)
         && (32'(top_cur) < MAX_PROD_LEN);
      len_wr = cmd.write_store && it_type_ff == ll1p_pkg::REQ_WRITE_SYMBOL
         && 32'(it_prod_ff) < NUM_PRODUCTIONS && 32'(it_pos_ff) < MAX_PROD_LEN;
      // Position 0 restarts the body; a higher position only grows it.
      if (it_pos_ff == '0) new_len = 5'd1;
      else if (len_old_ff < 5'(it_pos_ff) + 5'd1) new_len = 5'(it_pos_ff) + 5'd1;
      else new_len = len_old_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_count_ff <= '0;
         empty_sym_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == ll1p_pkg::CSR_PRODUCTION_COUNT) prod_count_ff <= csr_data[6:0];
         else empty_sym_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         it_type_ff <= req_type;
         it_prod_ff <= req_production;
         it_pos_ff <= req_position;
         it_sym_ff <= req_symbol;
         it_slot_ff <= req_table_slot;
         it_key_ff <= {req_key_nonterminal, req_key_token};
         it_kv_ff <= req_entry_valid;
      end
   end

   // Production symbol store, length store and table memories.
   always_ff @(posedge clock) begin
      if (len_wr) begin
         sym_mem[{it_prod_ff[PB-1:0], it_pos_ff[LB-1:0]}] <= it_sym_ff;
         len_mem[it_prod_ff[PB-1:0]] <= new_len;
      end
      if (cmd.write_store && it_type_ff == ll1p_pkg::REQ_WRITE_SLOT
          && 32'(it_slot_ff) < TABLE_SLOTS) begin
         key_mem[it_slot_ff[TB-1:0]] <= it_key_ff;
         tgt_mem[it_slot_ff[TB-1:0]] <= it_prod_ff;
      end
      if (cmd.load_item)
         len_old_ff <= len_set_ff[req_production[PB-1:0]] ?
                       len_mem[req_production[PB-1:0]] : '0;
      if (cmd.fetch) begin
         sym_rd_ff <= sym_mem[{top_prod[PB-1:0], top_cur[LB-1:0]}];
         len_rd_ff <= len_set_ff[top_prod[PB-1:0]] ? len_mem[top_prod[PB-1:0]] : '0;
      end
      key_rd_ff <= key_mem[scan_ff[TB-1:0]];
      tgt_rd_ff <= tgt_mem[scan_ff[TB-1:0]];
   end

   // A length reads as zero until its production is first written.
   always_ff @(posedge clock) begin
      if (reset) begin
         len_set_ff <= '0;
         tvalid_ff <= '0;
      end else begin
         if (len_wr) len_set_ff[it_prod_ff[PB-1:0]] <= 1'b1;
         if (cmd.write_store && it_type_ff == ll1p_pkg::REQ_WRITE_SLOT
             && 32'(it_slot_ff) < TABLE_SLOTS)
            tvalid_ff[it_slot_ff[TB-1:0]] <= it_kv_ff;
      end
   end

   // Fetch validity tracks the read of the symbol store.
   always_ff @(posedge clock) begin
      if (cmd.fetch) have_ff <= fetch_ok;
   end

   // Stack.
   always_ff @(posedge clock) begin
      if (reset || cmd.restart) begin
         for (int i = 0; i < STACK_DEPTH; i++) begin
            stk_prod_ff[i] <= '0;
            stk_cur_ff[i] <= '0;
         end
         stk_prod_ff[0] <= 6'd1;
         stk_cur_ff[0] <= 5'd1;
         level_ff <= LVB'(1);
         finished_ff <= '0;
      end else begin
         if (cmd.pop) begin
            level_ff <= level_ff - LVB'(1);
            if (level_ff != LVB'(1)) stk_cur_ff[below] <= stk_cur_ff[below] + 5'd1;
         end
         if (cmd.advance) stk_cur_ff[top] <= top_cur + 5'd1;
         if (cmd.push) begin
            stk_prod_ff[SB'(level_ff)] <= hit_tgt_ff;
            stk_cur_ff[SB'(level_ff)] <= 5'd1;
            level_ff <= level_ff + LVB'(1);
         end
         if (cmd.finish != 2'd0) finished_ff <= cmd.finish;
      end
   end

   // Lowest valid matching slot, one slot a cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
         rd_pend_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else if (cmd.search_start) begin
         scan_ff <= '0;
         rd_pend_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else if (cmd.search_step) begin
         if (rd_pend_ff && kv_rd_ff && key_rd_ff == {sym_rd_ff, it_sym_ff}) begin
            hit_ff <= 1'b1;
            hit_tgt_ff <= tgt_rd_ff;
         end
         if (32'(scan_ff) < TABLE_SLOTS) scan_ff <= scan_ff + (TB+1)'(1);
         rd_pend_ff <= 32'(scan_ff) < TABLE_SLOTS;
         kv_rd_ff <= tvalid_ff[scan_ff[TB-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load_item) begin
         exp_ff <= '0;
         rep_ff <= 1'b0;
      end else begin
         if (cmd.push) exp_ff <= exp_ff + EB'(1);
         if (cmd.set_repaired) rep_ff <= 1'b1;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (cmd.emit_expand || cmd.emit_status) out_valid_ff <= 1'b1;
      else if (rsp_ready) out_valid_ff <= 1'b0;
      if (cmd.emit_expand) begin
         out_kind_ff <= 1'b0;
         out_prod_ff <= hit_tgt_ff;
         out_status_ff <= ll1p_pkg::ST_MATCHED;
         out_rep_ff <= 1'b0;
      end else if (cmd.emit_status) begin
         out_kind_ff <= 1'b1;
         out_prod_ff <= '0;
         out_status_ff <= cmd.status;
         out_rep_ff <= rep_ff && cmd.status != ll1p_pkg::ST_DONE;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_kind = out_kind_ff;
   assign rsp_applied_production = out_prod_ff;
   assign rsp_status = out_status_ff;
   assign rsp_repaired = out_rep_ff;
   assign rsp_last = out_kind_ff;

   always_comb begin
      stat.req_type = it_type_ff;
      stat.stopped = finished_ff != 2'd0 || level_ff == '0;
      stat.top_over = 32'(level_ff) > STACK_DEPTH;
      stat.have_sym = have_ff && top_cur < len_rd_ff && sym_rd_ff != empty_sym_ff;
      stat.level_one = level_ff == LVB'(1);
      stat.sym_eq = sym_rd_ff == it_sym_ff;
      stat.sym_nt = 32'(sym_rd_ff) >= ll1p_pkg::NONTERMINAL_BASE;
      stat.sym_bracket = 32'(sym_rd_ff) >= ll1p_pkg::BRACKET_LO
         && 32'(sym_rd_ff) <= ll1p_pkg::BRACKET_HI;
      stat.search_done = hit_ff || (!rd_pend_ff && 32'(scan_ff) >= TABLE_SLOTS);
      stat.search_hit = hit_ff;
      stat.exp_limit = 32'(exp_ff) >= MAX_EXPANSIONS;
      stat.stack_full = 32'(level_ff) >= STACK_DEPTH;
      stat.out_busy = out_valid_ff && !rsp_ready;
   end
endmodule

[rtl/ll1p_control.sv]
// Parser controller: sequences fetch, pop, expand, match and result steps.
module ll1p_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ll1p_pkg::stat_type stat,
   output ll1p_pkg::cmd_type  cmd
);
   ll1p_pkg::state_type state_ff, state_in;
   logic [2:0] status_ff, status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ll1p_pkg::S_IDLE;
         status_ff <= ll1p_pkg::ST_MATCHED;
      end else begin
         state_ff <= state_in;
         status_ff <= status_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      status_in = status_ff;
      case (state_ff)
         ll1p_pkg::S_IDLE: if (req_valid) state_in = ll1p_pkg::S_FETCH;
         ll1p_pkg::S_FETCH: begin
            if (stat.req_type != ll1p_pkg::REQ_TOKEN) state_in = ll1p_pkg::S_IDLE;
            else if (stat.stopped) begin
               status_in = ll1p_pkg::ST_DONE;
               state_in = ll1p_pkg::S_EMIT;
            end else if (stat.top_over) begin
               status_in = ll1p_pkg::ST_OVERFLOW;
               state_in = ll1p_pkg::S_EMIT;
            end else state_in = ll1p_pkg::S_DECIDE;
         end
         ll1p_pkg::S_DECIDE: begin
            if (!stat.have_sym) begin
               if (stat.level_one) begin
                  status_in = ll1p_pkg::ST_COMPLETE;
                  state_in = ll1p_pkg::S_EMIT;
               end else state_in = ll1p_pkg::S_FETCH;
            end else if (stat.sym_eq) begin
               status_in = ll1p_pkg::ST_MATCHED;
               state_in = ll1p_pkg::S_EMIT;
            end else if (stat.sym_nt) state_in = ll1p_pkg::S_SEARCH;
            else if (stat.sym_bracket) state_in = ll1p_pkg::S_FETCH;
            else begin
               status_in = ll1p_pkg::ST_MISMATCH;
               state_in = ll1p_pkg::S_EMIT;
            end
         end
         ll1p_pkg::S_SEARCH: begin
            if (stat.search_done) begin
               if (!stat.search_hit) begin
                  status_in = ll1p_pkg::ST_MISMATCH;
                  state_in = ll1p_pkg::S_EMIT;
               end else if (stat.exp_limit || stat.stack_full) begin
                  status_in = ll1p_pkg::ST_OVERFLOW;
                  state_in = ll1p_pkg::S_EMIT;
               end else state_in = ll1p_pkg::S_EXPAND;
            end
         end
         ll1p_pkg::S_EXPAND: if (!stat.out_busy) state_in = ll1p_pkg::S_FETCH;
         ll1p_pkg::S_EMIT: if (!stat.out_busy) state_in = ll1p_pkg::S_IDLE;
         default: state_in = ll1p_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      cmd.status = status_ff;
      case (state_ff)
         ll1p_pkg::S_IDLE: begin
            req_ready = 1'b1;
            cmd.load_item = req_valid;
         end
         ll1p_pkg::S_FETCH: begin
            cmd.write_store = 1'b1;
            cmd.restart = stat.req_type == ll1p_pkg::REQ_RESTART;
            cmd.fetch = stat.req_type == ll1p_pkg::REQ_TOKEN;
         end
         ll1p_pkg::S_DECIDE: begin
            if (!stat.have_sym) begin
               cmd.pop = 1'b1;
               if (stat.level_one) cmd.finish = 2'd1;
            end else if (stat.sym_eq) cmd.advance = 1'b1;
            else if (stat.sym_nt) cmd.search_start = 1'b1;
            else if (stat.sym_bracket) begin
               cmd.advance = 1'b1;
               cmd.set_repaired = 1'b1;
            end
         end
         ll1p_pkg::S_SEARCH: begin
            cmd.search_step = !stat.search_done;
            if (stat.search_done && stat.search_hit && (stat.exp_limit || stat.stack_full))
               cmd.finish = 2'd2;
         end
         ll1p_pkg::S_EXPAND: if (!stat.out_busy) begin
            cmd.push = 1'b1;
            cmd.emit_expand = 1'b1;
         end
         ll1p_pkg::S_EMIT: begin
            cmd.emit_status = !stat.out_busy;
            if (status_ff == ll1p_pkg::ST_OVERFLOW && !stat.out_busy) cmd.finish = 2'd2;
         end
         default: ;
      endcase
   end
endmodule

[rtl/ll1_predictive_token_parser.sv]
// Top level of the table-driven LL(1) token parser.
// Usage:
//  req_* carries one item: production symbol write, table slot write, token
//  or restart. Items are taken one at a time; ready is high while idle.
//  csr_* writes production_count (index 0) or empty_symbol (index 1); it is
//  always ready and is to be used only while the parser is idle.
//  rsp_* gives results: zero or more expansion reports (kind 0), then one
//  status (kind 1, last 1) per token. Loads and restarts give no result.
//  Sequencing: a load or restart passes through the fetch state and the
//  parser is then idle again. A token spends a fetch and a decide step on
//  each pop, skip or match, a table search slot by slot on each nonterminal,
//  a push step per expansion and a step for the status. Expansion and
//  status steps wait while the result register is full; the next item is
//  taken only after the status is written.
//  The result register holds its item while rsp_ready is low; the
//  controller waits before writing the next result.
//  Reset clears configuration, lengths, table valid bits and puts the stack
//  at production 1, cursor 1, parsing active.
module ll1_predictive_token_parser #(
   parameter int NUM_PRODUCTIONS = ll1p_pkg::NumProductions,
   parameter int MAX_PROD_LEN    = ll1p_pkg::MaxProdLen,
   parameter int TABLE_SLOTS     = ll1p_pkg::TableSlots,
   parameter int STACK_DEPTH     = ll1p_pkg::StackDepth,
   parameter int MAX_EXPANSIONS  = ll1p_pkg::MaxExpansions
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [5:0]  req_production,
   input  logic [3:0]  req_position,
   input  logic [11:0] req_symbol,
   input  logic [5:0]  req_table_slot,
   input  logic [11:0] req_key_nonterminal,
   input  logic [11:0] req_key_token,
   input  logic        req_entry_valid,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [11:0] csr_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [5:0]  rsp_applied_production,
   output logic [2:0]  rsp_status,
   output logic        rsp_repaired,
   output logic        rsp_last
);
   ll1p_pkg::cmd_type  cmd;
   ll1p_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   ll1p_control u_control (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .stat(stat), .cmd(cmd)
   );

   ll1p_datapath #(
      .NUM_PRODUCTIONS(NUM_PRODUCTIONS), .MAX_PROD_LEN(MAX_PROD_LEN),
      .TABLE_SLOTS(TABLE_SLOTS), .STACK_DEPTH(STACK_DEPTH),
      .MAX_EXPANSIONS(MAX_EXPANSIONS)
   ) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_type(req_type), .req_production(req_production),
      .req_position(req_position), .req_symbol(req_symbol),
      .req_table_slot(req_table_slot), .req_key_nonterminal(req_key_nonterminal),
      .req_key_token(req_key_token), .req_entry_valid(req_entry_valid),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind), .rsp_applied_production(rsp_applied_production),
      .rsp_status(rsp_status), .rsp_repaired(rsp_repaired), .rsp_last(rsp_last)
   );
endmodule

[rtl/ll1p_checker.sv]
// Port checker for the LL(1) token parser.
module ll1p_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_kind,
   input logic [5:0] rsp_applied_production,
   input logic [2:0] rsp_status,
   input logic       rsp_repaired,
   input logic       rsp_last
);
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last == rsp_kind) else $error("last differs from kind");
   a_expand_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> rsp_status == 3'd0 && !rsp_repaired)
      else $error("expansion report carries status");
   a_status_prod: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_applied_production == 6'd0 && rsp_status <= 3'd4)
      else $error("bad status result");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_kind)
      && $stable(rsp_applied_production))
      else $error("result changed while stalled");
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while an item is in work");
endmodule

bind ll1_predictive_token_parser ll1p_checker u_ll1p_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
   .rsp_applied_production(rsp_applied_production), .rsp_status(rsp_status),
   .rsp_repaired(rsp_repaired), .rsp_last(rsp_last)
);
